### rtl/assert_macros.svh
// Assertion helper macros for the RTL modules.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/mrrf_pkg.sv
// Constants, register indexes and the CRC byte update for the read request framer.
// No dependencies.
package mrrf_pkg;

    localparam int unsigned CfgIdxW = 8;

    localparam logic [CfgIdxW-1:0] CFG_SLAVE_ADDRESS  = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_FUNCTION_CODE  = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_REGISTER_COUNT = 8'd2;

    localparam logic [7:0]  RST_SLAVE_ADDRESS  = 8'h01;
    localparam logic [7:0]  RST_FUNCTION_CODE  = 8'h04;
    localparam logic [15:0] RST_REGISTER_COUNT = 16'h0002;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [2:0] t_byte_pos;

    localparam t_byte_pos POS_SLAVE    = 3'd0;
    localparam t_byte_pos POS_FUNCTION = 3'd1;
    localparam t_byte_pos POS_ADDR_HI  = 3'd2;
    localparam t_byte_pos POS_ADDR_LO  = 3'd3;
    localparam t_byte_pos POS_COUNT_HI = 3'd4;
    localparam t_byte_pos POS_COUNT_LO = 3'd5;
    localparam t_byte_pos POS_CRC_LO   = 3'd6;
    localparam t_byte_pos POS_CRC_HI   = 3'd7;

    // Reflected CRC-16/MODBUS over one byte, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

### rtl/modbus_read_request_framer_core.sv
// Modbus RTU read request framer: address in, eight frame bytes out.
// Depends on mrrf_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one 16-bit start address
//   per item. Each item yields eight output items on o_out_valid /
//   i_out_stall: slave address, function code, address high, address low,
//   register count high, register count low, CRC low, CRC high. The last
//   one has o_last_byte set.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes slave address
//   (index 0), function code (1) and register count (2); other indexes are
//   dropped. Write only while no frame is in flight.
//   The address passes through the input register and the frame sequencer
//   into the output register. Bytes go out one per cycle while the receiver
//   does not stall, set by the single byte-wide output; the CRC advances one
//   byte per emitted header byte. A one-entry input register holds the next
//   address while the current frame is sent, so frames follow each other
//   with no gap. Reset restores the configuration defaults (1, 4, 2) and
//   empties the input register, the frame sequencer and the output register.
//   When the receiver stalls, the output byte holds and the sequencer
//   freezes; the input register fills and then stalls the sender.
module modbus_read_request_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // address items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_start_address,
    // frame bytes
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [mrrf_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "assert_macros.svh"

    // configuration registers
    logic [7:0]  r_slave_address;
    logic [7:0]  r_function_code;
    logic [15:0] r_register_count;

    // input register
    logic        r_in_vld;
    logic [15:0] r_in_addr;

    // frame sequencer
    logic                r_busy;
    mrrf_pkg::t_byte_pos r_pos;
    logic [15:0]         r_addr;
    logic [15:0]         r_crc;

    // output register
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       out_free;
    logic       emit;
    logic       take;
    logic       in_accept;
    logic [7:0] n_byte;
    logic       n_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_vld;
    assign in_accept   = i_in_valid && !r_in_vld;

    // output register can load when empty or being drained
    assign out_free = !r_out_vld || !i_out_stall;
    assign emit     = r_busy && out_free;
    // hand the next address to the sequencer when it is idle or sends its last byte
    assign take     = r_in_vld && (!r_busy || (emit && r_pos == mrrf_pkg::POS_CRC_HI));

    // select the byte for the current position
    always_comb begin
        n_last = 1'b0;
        case (r_pos)
            mrrf_pkg::POS_SLAVE:    n_byte = r_slave_address;
            mrrf_pkg::POS_FUNCTION: n_byte = r_function_code;
            mrrf_pkg::POS_ADDR_HI:  n_byte = r_addr[15:8];
            mrrf_pkg::POS_ADDR_LO:  n_byte = r_addr[7:0];
            mrrf_pkg::POS_COUNT_HI: n_byte = r_register_count[15:8];
            mrrf_pkg::POS_COUNT_LO: n_byte = r_register_count[7:0];
            mrrf_pkg::POS_CRC_LO:   n_byte = r_crc[7:0];
            mrrf_pkg::POS_CRC_HI: begin
                n_byte = r_crc[15:8];
                n_last = 1'b1;
            end
            default:                n_byte = 8'h00;
        endcase
    end

    // configuration writes; out-of-range indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address  <= mrrf_pkg::RST_SLAVE_ADDRESS;
            r_function_code  <= mrrf_pkg::RST_FUNCTION_CODE;
            r_register_count <= mrrf_pkg::RST_REGISTER_COUNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mrrf_pkg::CFG_SLAVE_ADDRESS:  r_slave_address  <= i_cfg_data[7:0];
                mrrf_pkg::CFG_FUNCTION_CODE:  r_function_code  <= i_cfg_data[7:0];
                mrrf_pkg::CFG_REGISTER_COUNT: r_register_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_addr <= i_start_address;
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= mrrf_pkg::POS_SLAVE;
        end else if (take) begin
            r_busy <= 1'b1;
            r_pos  <= mrrf_pkg::POS_SLAVE;
        end else if (emit) begin
            r_busy <= (r_pos != mrrf_pkg::POS_CRC_HI);
            r_pos  <= r_pos + 3'd1;
        end
    end

    // sequencer payload: advance the CRC over the six header bytes as they go out
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_addr <= r_in_addr;
            r_crc  <= mrrf_pkg::CRC_INIT;
        end else if (emit && r_pos <= mrrf_pkg::POS_COUNT_LO) begin
            r_crc <= mrrf_pkg::crc_byte(r_crc, n_byte);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= n_byte;
            r_out_last <= n_last;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

    // a frame is never dropped part way
    `ASSERT_NEXT(a_frame_continues, i_clk, i_rst_n,
        r_busy && r_pos != mrrf_pkg::POS_CRC_HI, r_busy)
    // a new address enters the sequencer only at a frame boundary
    `ASSERT_IMPLY(a_take_at_boundary, i_clk, i_rst_n,
        take, !r_busy || r_pos == mrrf_pkg::POS_CRC_HI)
    // an idle sequencer produces no byte
    `ASSERT_NEXT(a_idle_no_byte, i_clk, i_rst_n,
        !r_busy && out_free, !r_out_vld)
    // the last-byte flag appears only when the sequencer wrapped
    `ASSERT_IMPLY(a_last_wraps, i_clk, i_rst_n,
        r_out_vld && r_out_last && !r_busy, r_pos == mrrf_pkg::POS_SLAVE)

endmodule
